// ===== rtl/core/tlps_pkg.sv =====
// Shared types, constants and lookup functions for the traffic light phase sequencer.
`default_nettype none
package tlps_pkg;

   localparam int ElapsedW  = 14;
   localparam int QuarterW  = 12;
   localparam int PhaseW    = 4;
   localparam int BarW      = 8;
   localparam int RateW     = 16;

   localparam logic [ElapsedW-1:0] ElapsedMax = {ElapsedW{1'b1}};
   localparam logic [ElapsedW-1:0] BlinkMs    = ElapsedW'(500);
   localparam logic [PhaseW-1:0]   PhaseYellow  = 4'd4;
   localparam logic [PhaseW-1:0]   PhaseLastRed = 4'd8;
   localparam logic [PhaseW-1:0]   PhaseRestart = 4'd9;
   localparam logic [PhaseW-1:0]   PhaseLastGrn = 4'd3;

   // Register indexes on the configuration port
   localparam logic [1:0] RegManualMode = 2'd0;
   localparam logic [1:0] RegGreen      = 2'd1;
   localparam logic [1:0] RegYellow     = 2'd2;
   localparam logic [1:0] RegRed        = 2'd3;

   // Phase durations derived from the current rate and settings
   typedef struct packed {
      logic [QuarterW-1:0] green_ms;
      logic [QuarterW-1:0] red_ms;
   } dur_type;

   // Clamp a 4-bit setting to 1..9
   function automatic logic [3:0] clamp19(input logic [3:0] v);
      logic [3:0] r;
      if (v == 4'd0) r = 4'd1;
      else if (v > 4'd9) r = 4'd9;
      else r = v;
      return r;
   endfunction

   // 1..9 quarter steps, in ms
   function automatic logic [QuarterW-1:0] quarter_ms(input logic [3:0] v);
      logic [QuarterW-1:0] r;
      case (v)
         4'd1: r = 12'd250;
         4'd2: r = 12'd500;
         4'd3: r = 12'd750;
         4'd4: r = 12'd1000;
         4'd5: r = 12'd1250;
         4'd6: r = 12'd1500;
         4'd7: r = 12'd1750;
         4'd8: r = 12'd2000;
         4'd9: r = 12'd2250;
         default: r = 12'd0;
      endcase
      return r;
   endfunction

   // 1..9 seconds, in ms
   function automatic logic [ElapsedW-1:0] second_ms(input logic [3:0] v);
      logic [ElapsedW-1:0] r;
      case (v)
         4'd1: r = 14'd1000;
         4'd2: r = 14'd2000;
         4'd3: r = 14'd3000;
         4'd4: r = 14'd4000;
         4'd5: r = 14'd5000;
         4'd6: r = 14'd6000;
         4'd7: r = 14'd7000;
         4'd8: r = 14'd8000;
         4'd9: r = 14'd9000;
         default: r = 14'd0;
      endcase
      return r;
   endfunction

   // Lamp pattern of a phase: bit 8 is yellow, bits 7:0 the bar
   function automatic logic [8:0] lamp_pattern(input logic [PhaseW-1:0] ph);
      logic [8:0] r;
      case (ph)
         4'd0: r = 9'b000001111;
         4'd1: r = 9'b000000111;
         4'd2: r = 9'b000000011;
         4'd3: r = 9'b000000001;
         4'd4: r = 9'b100000000;
         4'd5: r = 9'b011110000;
         4'd6: r = 9'b001110000;
         4'd7: r = 9'b000110000;
         4'd8: r = 9'b000010000;
         default: r = 9'b000000000;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tlps_dur.sv =====
// Green and red phase durations from car rate or manual settings.
`default_nettype none
module tlps_dur (
   input  wire logic                       manual_mode,
   input  wire logic [3:0]                 green_setting,
   input  wire logic [3:0]                 red_setting,
   input  wire logic [tlps_pkg::RateW-1:0] cars_per_minute,
   output tlps_pkg::dur_type               dur
);
   import tlps_pkg::*;

   logic       rate_hi;
   logic [2:0] q;
   logic [3:0] green;
   logic [3:0] red;

   // rate/60 matters only below 8; count the thresholds passed
   always_comb begin
      rate_hi = (cars_per_minute >= RateW'(480));
      q = 3'd0;
      for (int k = 1; k < 8; k++) begin
         if (cars_per_minute >= RateW'(60 * k)) q = 3'(k);
      end
   end

   always_comb begin
      if (manual_mode) begin
         green = clamp19(green_setting);
         red   = clamp19(red_setting);
      end else if (rate_hi) begin
         green = 4'd1;
         red   = 4'd9;
      end else begin
         green = 4'd9 - {1'b0, q};
         red   = {1'b0, q} + 4'd1;
      end
      dur.green_ms = quarter_ms(green);
      dur.red_ms   = quarter_ms(red);
   end

endmodule
`default_nettype wire

// ===== rtl/core/traffic_light_phase_sequencer.sv =====
// Top level of the traffic light phase sequencer: tick pipeline, phase state and CSRs.
//
//   channel  direction  ports                      payload
//   req      in         req_tvalid/tready/tdata    one millisecond tick
//   rsp      out        rsp_tvalid/tready/tdata    lamp pattern for that tick
//   csr      in         csr_valid/ready/index/wdata register write
//
// Two register stages per tick: the input stage captures the tick together with the
// green and red durations derived from its car rate or the manual settings; the state
// stage updates phase and elapsed time and loads the result register. One tick per
// clock sustained while the result is not stalled. Reset (synchronous) clears both
// stages, the phase state and the CSRs to their defaults. A stalled result holds its
// register; the input stage still takes a transaction while it is empty.
`default_nettype none
module traffic_light_phase_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [23:0] req_tdata,   // [0] emergency_active, [16:1] cars_per_minute
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,   // [7:0] bar_lamps, [8] yellow_lamp,
                                         // [9] alert_lamp, [13:10] phase_now
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [3:0]  csr_wdata
);
   import tlps_pkg::*;

   // Configuration registers
   logic       manual_ff;
   logic [3:0] green_set_ff;
   logic [3:0] yellow_set_ff;
   logic [3:0] red_set_ff;

   // Input stage
   logic          s1_vld_ff;
   logic          s1_emerg_ff;
   dur_type       s1_dur_ff;
   dur_type       dur_in;

   // Phase state
   logic [PhaseW-1:0]   phase_ff,   phase_in;
   logic [ElapsedW-1:0] elapsed_ff, elapsed_in;
   logic                blink_ff,   blink_in;
   logic                yel_ff,     yel_in;
   logic                alert_ff,   alert_in;

   // Result register
   logic        rsp_vld_ff;
   logic [15:0] rsp_data_ff, rsp_data_in;

   logic                advance;
   logic                step;
   logic [8:0]          pattern;
   logic [ElapsedW-1:0] el_inc;
   logic [ElapsedW-1:0] dur_ms;

   // Always accept configuration; the user must write only while idle, not enforced here
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         manual_ff     <= 1'b0;
         green_set_ff  <= 4'd1;
         yellow_set_ff <= 4'd1;
         red_set_ff    <= 4'd1;
      end else if (csr_valid) begin
         case (csr_index)
            RegManualMode: manual_ff     <= csr_wdata[0];
            RegGreen:      green_set_ff  <= csr_wdata;
            RegYellow:     yellow_set_ff <= csr_wdata;
            RegRed:        red_set_ff    <= csr_wdata;
            default:       manual_ff     <= manual_ff;
         endcase
      end
   end

   // Advance the pipeline whenever the result register is free or being drained
   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = !s1_vld_ff || advance;
   assign step       = s1_vld_ff && advance;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   tlps_dur u_dur (
      .manual_mode     (manual_ff),
      .green_setting   (green_set_ff),
      .red_setting     (red_set_ff),
      .cars_per_minute (req_tdata[16:1]),
      .dur             (dur_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_tready) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_emerg_ff <= req_tdata[0];
         s1_dur_ff   <= dur_in;
      end
   end

   // Phase update for the tick held in the input stage
   always_comb begin
      pattern = lamp_pattern(phase_ff);
      el_inc  = (elapsed_ff == ElapsedMax) ? elapsed_ff : elapsed_ff + 1'b1;

      if (phase_ff <= PhaseLastGrn)       dur_ms = ElapsedW'(s1_dur_ff.green_ms);
      else if (phase_ff == PhaseYellow)   dur_ms = second_ms(clamp19(yellow_set_ff));
      else if (phase_ff <= PhaseLastRed)  dur_ms = ElapsedW'(s1_dur_ff.red_ms);
      else                                dur_ms = '0;

      phase_in   = phase_ff;
      elapsed_in = el_inc;
      blink_in   = blink_ff;
      yel_in     = yel_ff;
      alert_in   = alert_ff;

      if (!s1_emerg_ff) begin
         alert_in = 1'b0;
         yel_in   = pattern[8];
         if (phase_ff >= PhaseRestart) begin
            phase_in   = '0;
            elapsed_in = '0;
         end else if (el_inc >= dur_ms) begin
            phase_in   = phase_ff + 1'b1;
            elapsed_in = el_inc - dur_ms;
         end
      end else if (el_inc >= BlinkMs) begin
         // Alternate blink lamps; the yellow blink forces the yellow phase
         if (blink_ff) begin
            yel_in   = 1'b1;
            alert_in = 1'b0;
            phase_in = PhaseYellow;
         end else begin
            yel_in   = 1'b0;
            alert_in = 1'b1;
         end
         blink_in   = !blink_ff;
         elapsed_in = '0;
      end

      rsp_data_in = {2'b00, phase_ff, alert_in, yel_in, pattern[BarW-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         elapsed_ff <= '0;
         blink_ff   <= 1'b0;
         yel_ff     <= 1'b0;
         alert_ff   <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         blink_ff   <= blink_in;
         yel_ff     <= yel_in;
         alert_ff   <= alert_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   // Phase never leaves the restart range
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PhaseRestart)
      else $error("phase register out of range");

   // Blink lamps never light together
   a_lamps_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(yel_ff && alert_ff))
      else $error("yellow and alert lamps both latched");

   // A processed tick always lands in the result register
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_vld_ff)
      else $error("tick lost between stages");

   // Normal-mode ticks never report the alert lamp
   a_alert_normal: assert property (@(posedge clock) disable iff (reset)
      (step && !s1_emerg_ff) |=> !rsp_data_ff[9])
      else $error("alert lamp set outside emergency mode");
`endif

endmodule
`default_nettype wire
